/* rtl/imd_pkg.sv */
package imd_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int WIN_BYTES = 12;
  localparam logic [WIN_BYTES*8-1:0] TAG_TEXT = "icy-metaint:";
  localparam logic [31:0] BLANK_LINE = 32'h0D0A_0D0A;

  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int META_WIDTH = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_AUDIO  = 2'd1,
    PH_META   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DM_IDLE   = 2'd0,
    DM_SPACES = 2'd1,
    DM_DIGITS = 2'd2
  } digit_mode_t;

  typedef enum logic [1:0] {
    TP_WAIT = 2'd0,
    TP_IN   = 2'd1,
    TP_DONE = 2'd2
  } title_phase_t;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

/* rtl/imd_if.sv */
interface imd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface imd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;

  modport source (output valid, output out_byte, output kind, input ready);
  modport sink (input valid, input out_byte, input kind, output ready);
endinterface

/* rtl/imd_front.sv */
module imd_front import imd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  imd_in_if.sink        in_ch,
  input  logic          room,
  output push_t         push
);

  phase_t                    phase_r, phase_nxt;
  logic [WIN_BYTES*8-1:0]    win_r, win_nxt;
  digit_mode_t               dmode_r, dmode_nxt;
  logic [COUNT_WIDTH-1:0]    interval_r, interval_nxt;
  logic [COUNT_WIDTH-1:0]    audio_left_r, audio_left_nxt;
  logic [META_WIDTH-1:0]     meta_left_r, meta_left_nxt;
  title_phase_t              title_r, title_nxt;
  logic                      qheld_r, qheld_nxt;

  logic                      accept;
  logic [7:0]                b;
  logic [COUNT_WIDTH+3:0]    tenfold;
  logic                      last;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;
  assign b           = in_ch.data_byte;

  assign tenfold = {1'b0, interval_r, 3'b000} + {3'b000, interval_r, 1'b0}
                 + {{(COUNT_WIDTH-4){1'b0}}, (b - CHAR_ZERO)};
  assign last    = (meta_left_r - {{(META_WIDTH-1){1'b0}}, 1'b1}) == '0;

  always_comb begin
    phase_nxt      = phase_r;
    win_nxt        = win_r;
    dmode_nxt      = dmode_r;
    interval_nxt   = interval_r;
    audio_left_nxt = audio_left_r;
    meta_left_nxt  = meta_left_r;
    title_nxt      = title_r;
    qheld_nxt      = qheld_r;
    push           = '0;
    push.r0.kind   = KIND_AUDIO;
    push.r1.kind   = KIND_AUDIO;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (dmode_r == DM_SPACES && b == CHAR_SPACE) begin
            dmode_nxt = DM_SPACES;
          end else if (dmode_r != DM_IDLE && b >= CHAR_ZERO && b <= CHAR_NINE) begin
            interval_nxt = (tenfold[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0) ? COUNT_MAX
                         : tenfold[COUNT_WIDTH-1:0];
            dmode_nxt    = DM_DIGITS;
          end else begin
            dmode_nxt = DM_IDLE;
          end
          win_nxt = {win_r[WIN_BYTES*8-9:0], b};
          if (win_nxt == TAG_TEXT) begin
            interval_nxt = '0;
            dmode_nxt    = DM_SPACES;
          end
          if (win_nxt[31:0] == BLANK_LINE) begin
            phase_nxt      = PH_AUDIO;
            dmode_nxt      = DM_IDLE;
            audio_left_nxt = interval_nxt;
          end
        end
        PH_META: begin
          meta_left_nxt = meta_left_r - {{(META_WIDTH-1){1'b0}}, 1'b1};
          case (title_r)
            TP_WAIT: begin
              if (b == CHAR_QUOTE) begin
                title_nxt = TP_IN;
              end
            end
            TP_IN: begin
              if (qheld_r && b == CHAR_SEMI) begin
                qheld_nxt       = 1'b0;
                title_nxt       = TP_DONE;
                push.n          = 2'd1;
                push.r0.kind    = KIND_END;
              end else if (last) begin
                qheld_nxt = 1'b0;
                title_nxt = TP_DONE;
                if (qheld_r) begin
                  push.n           = 2'd2;
                  push.r0.out_byte = CHAR_QUOTE;
                  push.r0.kind     = KIND_TITLE;
                  push.r1.kind     = KIND_END;
                end else begin
                  push.n       = 2'd1;
                  push.r0.kind = KIND_END;
                end
              end else begin
                qheld_nxt = (b == CHAR_QUOTE);
                if (qheld_r) begin
                  push.n           = 2'd1;
                  push.r0.out_byte = CHAR_QUOTE;
                  push.r0.kind     = KIND_TITLE;
                  if (b != CHAR_QUOTE) begin
                    push.n           = 2'd2;
                    push.r1.out_byte = b;
                    push.r1.kind     = KIND_TITLE;
                  end
                end else if (b != CHAR_QUOTE) begin
                  push.n           = 2'd1;
                  push.r0.out_byte = b;
                  push.r0.kind     = KIND_TITLE;
                end
              end
            end
            default: begin
            end
          endcase
          if (last) begin
            phase_nxt      = PH_AUDIO;
            audio_left_nxt = interval_r;
            title_nxt      = TP_WAIT;
            qheld_nxt      = 1'b0;
          end
        end
        default: begin
          if (interval_r == '0) begin
            push.n           = 2'd1;
            push.r0.out_byte = b;
          end else if (audio_left_r != '0) begin
            audio_left_nxt   = audio_left_r - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            push.n           = 2'd1;
            push.r0.out_byte = b;
          end else begin
            meta_left_nxt = {b, 4'b0000};
            if (b == 8'd0) begin
              audio_left_nxt = interval_r;
            end else begin
              phase_nxt = PH_META;
              title_nxt = TP_WAIT;
              qheld_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      win_r        <= '0;
      dmode_r      <= DM_IDLE;
      interval_r   <= '0;
      audio_left_r <= '0;
      meta_left_r  <= '0;
      title_r      <= TP_WAIT;
      qheld_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      win_r        <= win_nxt;
      dmode_r      <= dmode_nxt;
      interval_r   <= interval_nxt;
      audio_left_r <= audio_left_nxt;
      meta_left_r  <= meta_left_nxt;
      title_r      <= title_nxt;
      qheld_r      <= qheld_nxt;
    end
  end

  // Header bytes never produce a transfer on the result side.
  a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (push.n == 2'd0))
    else $error("header byte produced a result");

  // A metadata body is never entered with nothing left in it.
  a_meta_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_META) |-> (meta_left_r != '0))
    else $error("metadata phase with empty block");

  // Audio results only come from the audio phase.
  a_audio_source: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && push.r0.kind == KIND_AUDIO) |-> (phase_r == PH_AUDIO))
    else $error("audio result outside audio phase");

endmodule

/* rtl/imd_queue.sv */
module imd_queue import imd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  output logic   room,
  output logic   head_valid,
  output res_t   head,
  input  logic   pop
);

  res_t                  mem_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wp_r, wp_nxt;
  logic [QPTR_WIDTH-1:0] rp_r, rp_nxt;
  logic [QCNT_WIDTH-1:0] count_r, count_nxt;
  logic [QPTR_WIDTH-1:0] wp_next_slot;

  assign room         = count_r <= QCNT_WIDTH'(QUEUE_DEPTH - 2);
  assign head_valid   = count_r != '0;
  assign head         = mem_r[rp_r];
  assign wp_next_slot = wp_r + {{(QPTR_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    wp_nxt    = wp_r + QPTR_WIDTH'(push.n);
    rp_nxt    = rp_r + {{(QPTR_WIDTH-1){1'b0}}, pop};
    count_nxt = count_r + QCNT_WIDTH'(push.n) - {{(QCNT_WIDTH-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp_next_slot] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != QCNT_WIDTH'(QUEUE_DEPTH)) |->
      (QCNT_WIDTH'(QPTR_WIDTH'(wp_r - rp_r)) == count_r))
    else $error("queue pointers disagree with count");

endmodule

/* rtl/imd_back.sv */
module imd_back import imd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  res_t      head,
  output logic      pop,
  imd_out_if.source out_ch
);

  logic       valid_r, valid_nxt;
  res_t       res_r, res_nxt;

  assign pop = head_valid && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (pop) begin
      valid_nxt = 1'b1;
      res_nxt   = head;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.out_byte = res_r.out_byte;
  assign out_ch.kind     = res_r.kind;

endmodule

/* rtl/icy_metadata_stream_demux.sv */
// Splits a received radio stream, one byte per transfer, into audio bytes and
// title characters. Header bytes are parsed for the metadata interval and the
// blank line and give no result; each audio byte gives one result, and each
// metadata byte gives zero, one or two (a held quote and the next character,
// or a held quote and the end marker). The block takes one byte per cycle while
// its queue has room and sends at most one result per cycle from its output
// register, so a run of bytes that each yield two results is limited by the
// output side; a four-entry result queue between parser and output stage
// absorbs short bursts, and the input is held off while fewer than two queue
// entries are free. A result is written into the queue and then passes through
// the output register before it appears on the output.
module icy_metadata_stream_demux import imd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  imd_in_if.sink     in_ch,
  imd_out_if.source  out_ch
);

  push_t push;
  logic  room;
  logic  head_valid;
  res_t  head;
  logic  pop;

  imd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  imd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  imd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
